[hw/rtl/pipc_pkg.sv]
// ----------------------------------------------------------------------------
// pipc_pkg
// Shared types, constants and helper functions for the crossing-number test.
// ----------------------------------------------------------------------------
package pipc_pkg;

  localparam int CoordW = 32;
  localparam int WordW  = 64;
  localparam int CfgW   = 32;
  localparam int DiffW  = 34;
  localparam int DivW   = 64;

  typedef enum logic [1:0] {
    OUT_NONE   = 2'd0,
    OUT_TOGGLE = 2'd1,
    OUT_BORDER = 2'd2
  } outcome_t;

  typedef enum logic {
    REG_QUERY_LAT = 1'b0,
    REG_QUERY_LON = 1'b1
  } reg_index_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic finish;
    logic clear;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
    logic div_busy;
  } dp_status_t;

  function automatic logic [CoordW-1:0] decode_lat(input logic [WordW-1:0] w);
    logic [CoordW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[31-i] = w[63-2*i];
      r[15-i] = w[31-2*i];
    end
    return r;
  endfunction

  function automatic logic [CoordW-1:0] decode_lon(input logic [WordW-1:0] w);
    logic [CoordW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[31-i] = w[62-2*i];
      r[15-i] = w[30-2*i];
    end
    return r;
  endfunction

endpackage

[hw/rtl/pipc_if.sv]
// ----------------------------------------------------------------------------
// pipc_vertex_if / pipc_outcome_if
// Valid/ready channels for vertex items and outcome items.
// ----------------------------------------------------------------------------
interface pipc_vertex_if;
  logic        valid;
  logic        ready;
  logic [63:0] coord_word;
  logic [31:0] cell_index;
  logic        last_vertex;
  modport source (output valid, coord_word, cell_index, last_vertex, input ready);
  modport sink   (input valid, coord_word, cell_index, last_vertex, output ready);
endinterface

interface pipc_outcome_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  modport source (output valid, outcome, input ready);
  modport sink   (input valid, outcome, output ready);
endinterface

[hw/rtl/pipc_div.sv]
// ----------------------------------------------------------------------------
// pipc_div
// Radix-4 restoring divider for 64-bit magnitudes, two quotient bits a cycle.
// ----------------------------------------------------------------------------
module pipc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pipc_pkg::DivW-1:0] dividend,
  input  logic [pipc_pkg::DivW-1:0] divisor,
  output logic                      busy,
  output logic [pipc_pkg::DivW-1:0] quotient
);
  logic [5:0]                count;
  logic [pipc_pkg::DivW-1:0] rem;
  logic [pipc_pkg::DivW-1:0] quo;
  logic [pipc_pkg::DivW-1:0] dvs;
  logic [pipc_pkg::DivW:0]   r1, r2, t1, t2;
  logic                      b1, b0;

  always_comb begin
    r1 = {rem, quo[63]};
    t1 = r1 - {1'b0, dvs};
    b1 = !t1[64];
    if (b1) r1 = t1;
    r2 = {r1[63:0], quo[62]};
    t2 = r2 - {1'b0, dvs};
    b0 = !t2[64];
    if (b0) r2 = t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
      rem   <= '0;
      quo   <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= r2[63:0];
      quo   <= {quo[61:0], b1, b0};
      count <= count + 6'd1;
      if (count == 6'd31) busy <= 1'b0;
    end
  end

  assign quotient = quo;
endmodule

[hw/rtl/pipc_datapath.sv]
// ----------------------------------------------------------------------------
// pipc_datapath
// Vertex decode, segment setup, two dividers that share one divisor and run state.
// ----------------------------------------------------------------------------
module pipc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  pipc_pkg::dp_cmd_t           cmd,
  output pipc_pkg::dp_status_t        status,
  input  logic [pipc_pkg::WordW-1:0]  word,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pipc_pkg::CfgW-1:0]   cfg_data,
  output logic [1:0]                  outcome
);
  logic [31:0] qlat, qlon;
  logic [31:0] prev_lat, prev_lon;
  logic        prev_west, parity, border, first;
  logic [31:0] lat, lon;

  // Pending segment test registers.
  logic        seg_do, seg_vert;
  logic [63:0] p_lo, p_hi;
  logic [63:0] seg_div;
  logic [31:0] seg_base;
  logic        pn_lo, pn_hi;

  logic [63:0] q_lo, q_hi;
  logic        busy_lo, busy_hi;

  // Latched input and setup.
  logic [31:0] v_lat, v_lon;

  always_comb begin
    lat = pipc_pkg::decode_lat(word);
    lon = pipc_pkg::decode_lon(word);
  end

  // Segment setup from the registered vertex against prev.
  logic signed [32:0] alon, blon, ql;
  logic        a_lt_b, rising;
  logic signed [33:0] d, x, dv;
  logic [31:0] base;
  logic signed [33:0] x_lo, x_hi;
  logic        lon_lt, lon_eq, plon_eq, span;
  logic signed [63:0] prod_lo, prod_hi;

  always_comb begin
    alon   = {prev_lon[31], prev_lon};
    blon   = {v_lon[31], v_lon};
    ql     = {qlon[31], qlon};
    a_lt_b = alon < blon;
    rising = prev_lat < v_lat;
    if (a_lt_b) begin
      d    = $signed({2'b0, v_lat}) - $signed({2'b0, prev_lat});
      dv   = 34'(blon) - 34'(alon) + 34'sd1;
      x    = 34'(ql) - 34'(alon);
      base = prev_lat;
      x_lo = rising ? x : x + 34'sd1;
      x_hi = rising ? x + 34'sd1 : x;
    end else begin
      d    = $signed({2'b0, prev_lat}) - $signed({2'b0, v_lat});
      dv   = 34'(alon) - 34'(blon) + 34'sd1;
      x    = 34'(ql) - 34'(blon);
      base = v_lat;
      x_lo = rising ? x + 34'sd1 : x;
      x_hi = rising ? x : x + 34'sd1;
    end
    prod_lo = 64'(d * x_lo);
    prod_hi = 64'(d * x_hi);
    lon_lt  = blon < ql;
    lon_eq  = v_lon == qlon;
    plon_eq = prev_lon == qlon;
    span    = (prev_lat <= qlat && v_lat >= qlat) || (v_lat <= qlat && prev_lat >= qlat);
  end

  logic [31:0] lo_v, hi_v;
  logic [63:0] sq_lo, sq_hi;
  always_comb begin
    sq_lo = pn_lo ? (~q_lo + 64'd1) : q_lo;
    sq_hi = pn_hi ? (~q_hi + 64'd1) : q_hi;
    lo_v  = sq_lo[31:0] + seg_base;
    hi_v  = sq_hi[31:0] + seg_base;
  end

  // Stage 1 (load): latch vertex. Stage 2 (div_start): classify and start division.
  logic stage_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      qlat <= '0; qlon <= '0;
      prev_lat <= '0; prev_lon <= '0;
      prev_west <= 1'b0; parity <= 1'b0; border <= 1'b0; first <= 1'b1;
      seg_do <= 1'b0; stage_v <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pipc_pkg::REG_QUERY_LAT) qlat <= cfg_data;
        else qlon <= cfg_data;
      end
      if (cmd.load) begin
        v_lat  <= lat;
        v_lon  <= lon;
      end
      if (cmd.div_start) begin
        // Classification of the latched vertex.
        seg_do <= 1'b0;
        if (first) begin
          first     <= 1'b0;
          parity    <= 1'b0;
          border    <= (v_lat == qlat) && (v_lon == qlon);
          prev_lat  <= v_lat;
          prev_lon  <= v_lon;
          prev_west <= lon_lt;
        end else if (!border) begin
          prev_lat <= v_lat;
          prev_lon <= v_lon;
          if (prev_west) begin
            if (!lon_lt) begin
              prev_west <= 1'b0;
              seg_do    <= 1'b1;
              seg_vert  <= 1'b0;
            end
          end else if (lon_eq && plon_eq && span) begin
            border <= 1'b1;
          end else if (lon_eq) begin
            seg_do   <= 1'b1;
            seg_vert <= 1'b1;
          end else if (lon_lt) begin
            prev_west <= 1'b1;
            seg_do    <= 1'b1;
            seg_vert  <= 1'b0;
          end
        end
        pn_lo    <= prod_lo[63];
        pn_hi    <= prod_hi[63];
        seg_base <= base;
        p_lo     <= prod_lo[63] ? 64'(-prod_lo) : prod_lo;
        p_hi     <= prod_hi[63] ? 64'(-prod_hi) : prod_hi;
        seg_div  <= 64'(dv);
      end
      if (cmd.finish) begin
        if (seg_do) begin
          seg_do <= 1'b0;
          // A vertex on the query longitude only checks for a border hit.
          if (lo_v <= qlat) begin
            if (hi_v >= qlat) border <= 1'b1;
            else if (!seg_vert) parity <= !parity;
          end
        end
      end
      if (cmd.clear) begin
        prev_lat <= '0; prev_lon <= '0;
        prev_west <= 1'b0; parity <= 1'b0; border <= 1'b0; first <= 1'b1;
        seg_do <= 1'b0;
      end
      stage_v <= cmd.div_start;
    end
  end

  pipc_div u_div_lo (.clk, .rst, .start(stage_v), .dividend(p_lo), .divisor(seg_div),
                     .busy(busy_lo), .quotient(q_lo));
  pipc_div u_div_hi (.clk, .rst, .start(stage_v), .dividend(p_hi), .divisor(seg_div),
                     .busy(busy_hi), .quotient(q_hi));

  always_comb begin
    status.need_div = seg_do;
    status.div_busy = busy_lo | busy_hi | stage_v;
    if (border) outcome = pipc_pkg::OUT_BORDER;
    else if (parity) outcome = pipc_pkg::OUT_TOGGLE;
    else outcome = pipc_pkg::OUT_NONE;
  end
endmodule

[hw/rtl/pipc_ctrl.sv]
// ----------------------------------------------------------------------------
// pipc_ctrl
// Sequencer: accept a vertex, classify, divide when needed, report on last.
// ----------------------------------------------------------------------------
module pipc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pipc_pkg::dp_cmd_t    cmd,
  input  pipc_pkg::dp_status_t status,
  input  logic [1:0]           outcome,
  output logic [1:0]           out_outcome
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLASS = 5'b00010,
    S_START = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   last_r;
  logic   ov;
  logic   report;

  assign in_ready = (state == S_IDLE) && !(ov && !out_ready);
  assign out_valid = ov;

  always_comb begin
    cmd = '0;
    state_next = state;
    report = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.div_start = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        state_next = status.need_div ? S_WAIT : S_DONE;
      end
      S_WAIT: begin
        if (!status.div_busy) begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (last_r) begin
          if (!ov || out_ready) begin
            report = 1'b1;
            cmd.clear = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (report) ov <= 1'b1;
      else if (out_ready) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) last_r <= in_last;
    if (report) out_outcome <= outcome;
  end
endmodule

[hw/rtl/point_in_polygon_crossing.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_crossing
// Streaming crossing-number point-in-polygon test, one vertex per transfer.
// ----------------------------------------------------------------------------
// Usage: configure query_lat (index 0) and query_lon (index 1) through the
// write port while the block is idle. Then send the vertices of one run on
// the vtx channel, the final one with last_vertex set. Each vertex is the
// coordinate word with the cell index ORed into its upper half, decoded into
// latitude and longitude. On the last vertex one transfer appears on the res
// channel: 0 no effect, 1 odd crossings, 2 point on the border.
// Each vertex passes through the states accept, classify and start, then a
// wait state when a segment test is needed, then done. The segment test
// uses the two radix-4 dividers, which run side by side for each test. A
// new vertex is taken only after the previous one is through, and the
// outcome of a run is registered in the done state of its last vertex.
// Reset clears the query point and all run state. When the receiver stalls,
// the outcome waits in its output register and no further vertex is taken
// until that outcome has been delivered.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing (
  input  logic                       clk,
  input  logic                       rst,
  pipc_vertex_if.sink                vtx,
  pipc_outcome_if.source             res,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pipc_pkg::CfgW-1:0]  cfg_data
);
  pipc_pkg::dp_cmd_t    cmd;
  pipc_pkg::dp_status_t status;
  logic [1:0]           outcome;
  logic [63:0]          word;

  // The cell index lands on the upper half of the coordinate word.
  assign word = vtx.coord_word | {vtx.cell_index, 32'd0};

  pipc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(vtx.valid), .in_ready(vtx.ready), .in_last(vtx.last_vertex),
    .out_valid(res.valid), .out_ready(res.ready),
    .cmd, .status, .outcome, .out_outcome(res.outcome)
  );

  pipc_datapath u_dp (
    .clk, .rst, .cmd, .status, .word,
    .cfg_we, .cfg_index, .cfg_data, .outcome
  );
endmodule

[hw/rtl/pipc_checker.sv]
// ----------------------------------------------------------------------------
// pipc_checker
// Port-level checks on the outcome and vertex channels, bound to the top level.
// ----------------------------------------------------------------------------
module pipc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] outcome,
  input logic       in_valid,
  input logic       in_ready
);
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outcome != 2'd3) else $error("bad outcome code");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome)) else $error("outcome dropped");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("vertex taken back to back");
endmodule

bind point_in_polygon_crossing pipc_checker u_chk (
  .clk, .rst, .out_valid(res.valid), .out_ready(res.ready), .outcome(res.outcome),
  .in_valid(vtx.valid), .in_ready(vtx.ready)
);

[tb/tb_pipc_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pipc_checker
// Watches the vertex, outcome and register channels of the crossing-number
// block, predicts each outcome and compares it with what the block sends.
// ----------------------------------------------------------------------------
module tb_pipc_checker
  import pipc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  pipc_vertex_if          vtx,
  pipc_outcome_if         res,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  output int              fail_count,
  output int              pending
);

  typedef enum logic [1:0] {SEG_MISS, SEG_BELOW, SEG_ON} seg_t;

  logic [31:0] q_lat, q_lon;
  logic [31:0] prior_lat, prior_lon;
  logic        last_west, parity, on_border, run_start;
  outcome_t    outcome_q[$];

  // Integer interpolation: base + trunc(d * x / dv), product wraps at 64 bits.
  function automatic logic [31:0] interp(longint d, longint x, longint dv,
                                         logic [31:0] base);
    bit [63:0] p, mag, q, udv;
    p   = d * x;
    mag = p[63] ? -p : p;
    udv = (dv > 0) ? dv : 64'd1;
    q   = mag / udv;
    if (p[63]) q = -q;
    return q[31:0] + base;
  endfunction

  function automatic seg_t seg_class(logic [31:0] alat, longint alon,
                                     logic [31:0] blat, longint blon);
    longint qlon;
    logic [31:0] lo, hi;
    logic rising;
    qlon   = longint'($signed(q_lon));
    rising = alat < blat;
    if (alon < blon) begin
      lo = interp(longint'(blat) - alat, rising ? qlon - alon : qlon - alon + 1,
                  blon - alon + 1, alat);
      hi = interp(longint'(blat) - alat, rising ? qlon - alon + 1 : qlon - alon,
                  blon - alon + 1, alat);
    end else begin
      lo = interp(longint'(alat) - blat, rising ? qlon - blon + 1 : qlon - blon,
                  alon - blon + 1, blat);
      hi = interp(longint'(alat) - blat, rising ? qlon - blon : qlon - blon + 1,
                  alon - blon + 1, blat);
    end
    if (lo > q_lat) return SEG_MISS;
    if (hi >= q_lat) return SEG_ON;
    return SEG_BELOW;
  endfunction

  // Advances the run state by one vertex that is not the first of its run.
  function automatic void follow_edge(logic [31:0] lat, logic [31:0] lon_bits);
    longint qlon, lon, plon;
    logic [31:0] plat;
    seg_t c;
    qlon = longint'($signed(q_lon));
    lon  = longint'($signed(lon_bits));
    plon = longint'($signed(prior_lon));
    plat = prior_lat;
    prior_lat = lat;
    prior_lon = lon_bits;
    if (last_west) begin
      if (lon < qlon) return;
      last_west = 1'b0;
    end else begin
      if (lon == qlon) begin
        if (plon == qlon && ((plat <= q_lat && lat >= q_lat) ||
                             (lat <= q_lat && plat >= q_lat))) begin
          on_border = 1'b1;
          return;
        end
        if (seg_class(plat, plon, lat, lon) == SEG_ON) begin
          on_border = 1'b1;
          return;
        end
      end
      if (lon >= qlon) return;
      last_west = 1'b1;
    end
    c = seg_class(plat, plon, lat, lon);
    if (c == SEG_ON) on_border = 1'b1;
    else if (c == SEG_BELOW) parity = !parity;
  endfunction

  task automatic report(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending = outcome_q.size();

  always @(posedge clk) begin
    logic [63:0] w;
    logic [31:0] lat, lon;
    outcome_t got, want;
    if (rst) begin
      q_lat = '0; q_lon = '0;
      prior_lat = '0; prior_lon = '0;
      last_west = 0; parity = 0; on_border = 0; run_start = 1;
      outcome_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_QUERY_LAT) q_lat = cfg_data;
        else q_lon = cfg_data;
      end
      if (vtx.valid && vtx.ready) begin
        w = vtx.coord_word | {vtx.cell_index, 32'h0};
        for (int i = 0; i < 16; i++) begin
          lat[31-i] = w[63-2*i]; lat[15-i] = w[31-2*i];
          lon[31-i] = w[62-2*i]; lon[15-i] = w[30-2*i];
        end
        if (run_start) begin
          run_start = 1'b0;
          parity    = 1'b0;
          on_border = (lat == q_lat) && (lon == q_lon);
          prior_lat = lat;
          prior_lon = lon;
          last_west = $signed(lon) < $signed(q_lon);
        end else if (!on_border) begin
          follow_edge(lat, lon);
        end
        if (vtx.last_vertex) begin
          outcome_q.push_back(on_border ? OUT_BORDER : (parity ? OUT_TOGGLE : OUT_NONE));
          prior_lat = '0; prior_lon = '0;
          last_west = 0; parity = 0; on_border = 0; run_start = 1;
        end
      end
      if (res.valid && res.ready) begin
        got = outcome_t'(res.outcome);
        if (outcome_q.size() == 0) begin
          report($sformatf("outcome %0d with none expected", got));
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) report($sformatf("outcome %0d, expected %0d", got, want));
        end
      end
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives polygon vertex runs and query points into the crossing-number block
// and gives the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import pipc_pkg::*;

  logic clk, rst;
  logic cfg_we, cfg_index;
  logic [CfgW-1:0] cfg_data;
  int fail_count, pending;
  int cycles;

  // The receiver holds its ready low for a long stretch while this is set,
  // and never idles while steady is set.
  logic hold, steady;

  pipc_vertex_if  vtx ();
  pipc_outcome_if res ();

  point_in_polygon_crossing i_dut (
    .clk, .rst, .vtx(vtx.sink), .res(res.source), .cfg_we, .cfg_index, .cfg_data
  );

  tb_pipc_checker i_checker (
    .clk, .rst, .vtx, .res, .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Watchdog: far above the slowest correct run, which is about 1100 vertices
  // plus stalls on both sides.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver side. Ready changes at the falling edge only, once per step.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold) res.ready <= 1'b0;
      else res.ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // One long hold-off of the receiver, counted in its own process, while the
  // sender keeps offering vertices so the block backs up and stalls its input.
  initial begin
    hold = 1'b0;
    repeat (3000) @(posedge clk);
    @(negedge clk);
    hold = 1'b1;
    repeat (600) @(posedge clk);
    @(negedge clk);
    hold = 1'b0;
  end

  // Packs a latitude and longitude into the interleaved coordinate word.
  function automatic logic [63:0] pack_vertex(logic [31:0] lat, logic [31:0] lon);
    logic [63:0] w;
    for (int i = 0; i < 16; i++) begin
      w[63-2*i] = lat[31-i]; w[31-2*i] = lat[15-i];
      w[62-2*i] = lon[31-i]; w[30-2*i] = lon[15-i];
    end
    return w;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offers one vertex and returns after its transfer. Idle cycles are put in
  // front of the offer at random unless steady is set.
  task automatic send(logic [63:0] word, logic [31:0] cell_idx, logic last);
    while (!steady && $urandom_range(99) < 20) begin
      vtx.valid = 1'b0;
      @(negedge clk);
    end
    vtx.valid = 1'b1;
    vtx.coord_word = word;
    vtx.cell_index = cell_idx;
    vtx.last_vertex = last;
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
    @(negedge clk);
    vtx.valid = 1'b0;
  endtask

  task automatic send_point(logic [31:0] lat, logic [31:0] lon, logic last);
    send(pack_vertex(lat, lon), 32'h0, last);
  endtask

  // A vertex near the query point: most are within a few units so that
  // crossings, borders and vertical edges through the point are common.
  task automatic send_near(logic [31:0] qlat, logic [31:0] qlon, logic last);
    int kind;
    longint lon;
    logic [31:0] lat;
    kind = $urandom_range(99);
    lat = qlat + $signed(32'($urandom_range(8)) - 4);
    lon = longint'($signed(qlon)) + $urandom_range(8) - 4;
    if (kind < 8) begin
      lat = qlat;
      lon = longint'($signed(qlon));
    end else if (kind < 20) begin
      lon = longint'($signed(qlon));
    end else if (kind < 85) begin
    end else if (kind < 95) begin
      lat = qlat + $signed(32'($urandom_range(2000)) - 1000);
      lon = longint'($signed(qlon)) + $urandom_range(2000) - 1000;
    end
    if (lon > 64'sd2147483647) lon = 64'sd2147483647;
    if (lon < -64'sd2147483648) lon = -64'sd2147483648;
    if (kind >= 95) begin
      // Fully random word; the cell index is sometimes set as well.
      send({$urandom, $urandom}, ($urandom_range(3) == 0) ? $urandom : 32'h0, last);
    end else if ($urandom_range(9) == 0) begin
      send(pack_vertex(lat, 32'(lon)),
           $urandom & 32'(~pack_vertex(lat, 32'(lon)) >> 32), last);
    end else begin
      send_point(lat, 32'(lon), last);
    end
  endtask

  task automatic wait_idle();
    wait (pending == 0);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    logic [31:0] qlat, qlon;
    int n, len;
    rst = 1'b1;
    steady = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_QUERY_LAT;
    cfg_data = '0;
    vtx.valid = 1'b0;
    vtx.coord_word = '0;
    vtx.cell_index = '0;
    vtx.last_vertex = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed runs at the reset query point (0, 0).
    send_point(32'd0, 32'd0, 1'b1);                  // single vertex on the point
    send_point(32'd5, 32'd3, 1'b1);                  // single vertex off the point
    send_point(32'd0, 32'hFFFF_FFFF, 1'b0);          // rectangle with the origin on its edge
    send_point(32'd0, 32'd1, 1'b0);
    send_point(32'd9, 32'd1, 1'b0);
    send_point(32'd9, 32'hFFFF_FFFF, 1'b0);
    send_point(32'd0, 32'hFFFF_FFFF, 1'b1);
    send_point(32'd3, 32'd0, 1'b0);                  // vertical edge on the query longitude
    send_point(32'hFFFF_FFF0, 32'd0, 1'b1);
    send_point(32'd0, 32'd0, 1'b0);                  // border hit, then ignored vertices
    send_point(32'd7, 32'd7, 1'b0);
    send_point(32'd7, 32'hFFFF_FFF9, 1'b1);
    send(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0); // extreme coordinates
    send(64'h0, 32'h0, 1'b0);
    send(64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0);
    send(64'hAAAA_AAAA_AAAA_AAAA, 32'h0, 1'b1);
    wait_idle();

    // Random phases, each with its own query point; the first four use fixed
    // points, among them the register extremes.
    for (int phase = 0; phase < 10; phase++) begin
      unique case (phase)
        0: begin qlat = 32'hFFFF_FFFF; qlon = 32'h7FFF_FFFF; end
        1: begin qlat = 32'h0;         qlon = 32'h8000_0000; end
        2: begin qlat = 32'h8000_0000; qlon = 32'h0;         end
        3: begin qlat = 32'd100;       qlon = 32'hFFFF_FF00; end
        default: begin qlat = $urandom; qlon = $urandom; end
      endcase
      write_reg(REG_QUERY_LAT, qlat);
      write_reg(REG_QUERY_LON, qlon);
      steady = (phase == 4);
      n = 0;
      while (n < 108) begin
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 3);
        for (int k = 0; k < len; k++) send_near(qlat, qlon, k == len - 1);
        n += len;
      end
      steady = 1'b0;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
